>>> hdl/dma_pkg.sv
// shared widths and register codes for the decimated moving average
// no dependencies; used by every module of the block
`default_nettype none

package dma_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ENTRY_W    = 17;
    localparam int AVG_W      = 17;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef logic [SAMPLE_W-1:0]        sample_t;
    typedef logic signed [ENTRY_W-1:0]  entry_t;
    typedef logic signed [AVG_W-1:0]    avg_t;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_SAMPLE_OFFSET = 1'b0
    } reg_index_t;

endpackage

`default_nettype wire

>>> hdl/dma_cell.sv
// one window cell: holds a single signed entry and passes it on
// depends on dma_pkg
`default_nettype none

module dma_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire dma_pkg::entry_t d,
    output dma_pkg::entry_t      q
);

    dma_pkg::entry_t value_reg;
    dma_pkg::entry_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (shift)
        begin
            value_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign q = value_reg;

endmodule

`default_nettype wire

>>> hdl/dma_window.sv
// sample window as a row of cells; the last cell holds the oldest entry
// depends on dma_pkg and dma_cell
`default_nettype none

module dma_window
#(
    parameter int WINDOW_LEN = 25
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire dma_pkg::entry_t din,
    output dma_pkg::entry_t      oldest
);

    dma_pkg::entry_t tap [WINDOW_LEN];

    for (genvar k = 0; k < WINDOW_LEN; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            dma_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (din),
                .q     (tap[k])
            );
        end
        else
        begin : g_body
            dma_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (tap[k-1]),
                .q     (tap[k])
            );
        end
    end

    assign oldest = tap[WINDOW_LEN-1];

endmodule

`default_nettype wire

>>> hdl/dma_div.sv
// divide the signed window sum by the window length, truncating toward zero
// four stage pipeline using a reciprocal multiply; depends on dma_pkg
`default_nettype none

module dma_div
#(
    parameter int WINDOW_LEN = 25
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic signed [dma_pkg::SAMPLE_W+$clog2(WINDOW_LEN):0] in_sum,
    output logic                                        in_ready,
    output logic                                        out_valid,
    output dma_pkg::avg_t                               out_avg,
    input  wire logic                                   out_stall
);

    localparam int LOG_W  = $clog2(WINDOW_LEN);
    localparam int MAG_W  = dma_pkg::SAMPLE_W + LOG_W;
    localparam int SUM_W  = MAG_W + 1;
    localparam int SHIFT  = MAG_W + LOG_W;
    localparam int MUL_W  = MAG_W + 1;
    localparam int PROD_W = MAG_W + MUL_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_FULL);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic [MAG_W-1:0]        s2_mag_reg;
    logic                    s2_neg_reg;
    logic [PROD_W-1:0]       s3_prod_reg;
    logic                    s3_neg_reg;
    dma_pkg::avg_t           s4_avg_reg;

    logic                    ld1, ld2, ld3, ld4;
    logic [MAG_W-1:0]        mag_next;
    logic [PROD_W-1:0]       prod_next;
    logic [dma_pkg::AVG_W-1:0] quot;
    dma_pkg::avg_t           avg_next;

    // a stage loads when it is empty or its contents move on
    assign ld4 = !v4_reg || !out_stall;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    always_comb
    begin
        mag_next  = s1_sum_reg[SUM_W-1] ? MAG_W'(-s1_sum_reg) : MAG_W'(s1_sum_reg);
        prod_next = PROD_W'(s2_mag_reg) * PROD_W'(RECIP);
        quot      = {1'b0, s3_prod_reg[SHIFT +: dma_pkg::SAMPLE_W]};
        avg_next  = s3_neg_reg ? -$signed(quot) : $signed(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_sum_reg <= in_sum;
        end
        if (ld2)
        begin
            s2_mag_reg <= mag_next;
            s2_neg_reg <= s1_sum_reg[SUM_W-1];
        end
        if (ld3)
        begin
            s3_prod_reg <= prod_next;
            s3_neg_reg  <= s2_neg_reg;
        end
        if (ld4)
        begin
            s4_avg_reg <= avg_next;
        end
    end

    assign in_ready  = ld1;
    assign out_valid = v4_reg;
    assign out_avg   = s4_avg_reg;

endmodule

`default_nettype wire

>>> hdl/decimated_moving_average.sv
`default_nettype none

// Boxcar moving average over the last WINDOW_LEN samples, with one result beat
// for every DECIMATION samples. Each raw_sample beat has sample_offset taken
// off and is shifted into a row of WINDOW_LEN cells; the entry leaving the row
// is taken out of a running sum and the new one added, so a sample is accepted
// every clock cycle unless sample_stall is high. The window and sum start at
// zero after reset (no clearing pass), so early averages include zero entries.
// Averages are the sum divided by WINDOW_LEN, truncated toward zero, computed
// by a four stage reciprocal multiply pipeline: its sum register loads at the
// sample's accepting edge, then the magnitude, product and average registers
// follow in turn. sample_stall rises only when a sample that yields a result
// finds the first divider stage held by a stalled output.

module decimated_moving_average
#(
    parameter int WINDOW_LEN = 25,
    parameter int DECIMATION = 5
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             sample_valid,
    output logic                                  sample_stall,
    input  wire logic [dma_pkg::SAMPLE_W-1:0]     raw_sample,
    output logic                                  average_valid,
    input  wire logic                             average_stall,
    output logic signed [dma_pkg::AVG_W-1:0]      window_average,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dma_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [dma_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dma_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int PH_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int SUM_W = dma_pkg::SAMPLE_W + POS_W + 1;
    localparam logic [PH_W-1:0]  EMIT_PHASE = PH_W'(1 % DECIMATION);
    localparam logic [PH_W-1:0]  LAST_PHASE = PH_W'(DECIMATION - 1);
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(WINDOW_LEN - 1);

    dma_pkg::sample_t        offset_reg;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [PH_W-1:0]         phase_reg, phase_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    dma_pkg::reg_index_t     reg_idx;
    logic                    cfg_write;
    logic                    accept;
    logic                    emit;
    logic                    div_ready;
    dma_pkg::entry_t         entry;
    dma_pkg::entry_t         oldest;

    // configuration port
    assign reg_idx   = dma_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (reg_idx)
            dma_pkg::REG_SAMPLE_OFFSET:
            begin
                prdata = dma_pkg::APB_DATA_W'(offset_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // position, decimation phase, entry and running sum after this sample
    always_comb
    begin
        if (pos_reg == LAST_POS)
        begin
            pos_next   = '0;
            phase_next = '0;
        end
        else
        begin
            pos_next   = pos_reg + POS_W'(1);
            phase_next = (phase_reg == LAST_PHASE) ? '0 : phase_reg + PH_W'(1);
        end
        entry    = $signed({1'b0, raw_sample}) - $signed({1'b0, offset_reg});
        sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(entry);
    end

    assign emit         = (phase_next == EMIT_PHASE);
    assign sample_stall = emit && !div_ready;
    assign accept       = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            pos_reg    <= '0;
            phase_reg  <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            if (cfg_write && reg_idx == dma_pkg::REG_SAMPLE_OFFSET)
            begin
                offset_reg <= pwdata[dma_pkg::SAMPLE_W-1:0];
            end
            if (accept)
            begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
            end
        end
    end

    dma_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (accept),
        .din    (entry),
        .oldest (oldest)
    );

    dma_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && emit),
        .in_sum    (sum_next),
        .in_ready  (div_ready),
        .out_valid (average_valid),
        .out_avg   (window_average),
        .out_stall (average_stall)
    );

    // an accepted result-bearing sample must find the divider ready
    a_emit_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && emit) |-> div_ready)
        else $error("sample with result accepted while divider busy");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("write position out of window");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= LAST_PHASE)
        else $error("decimation phase out of range");

    // phase restarts together with the position
    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) |-> (phase_reg == '0))
        else $error("phase not aligned with window wrap");

endmodule

`default_nettype wire

>>> tb/sv/decimated_moving_average_tb.sv
// self-checking bench for decimated_moving_average: random sample bursts,
// output stalls and offset register writes, checked against an in-bench boxcar model
// depends on dma_pkg and the decimated_moving_average rtl only
`timescale 1ns / 100ps

module decimated_moving_average_tb;

    localparam int WINDOW_LEN    = 25;
    localparam int DECIMATION    = 5;
    localparam int SETTLE_CYCLES = 10;
    localparam int QUIET_LIMIT   = 3000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [dma_pkg::APB_ADDR_W-1:0] OFFSET_ADDR =
        dma_pkg::APB_ADDR_W'(dma_pkg::REG_SAMPLE_OFFSET) << 2;
    localparam logic [dma_pkg::APB_ADDR_W-1:0] UNKNOWN_ADDR = 3'd4;

    logic                               clk;
    logic                               rst_n;
    logic                               sample_valid;
    logic                               sample_stall;
    dma_pkg::sample_t                   raw_sample;
    logic                               average_valid;
    logic                               average_stall;
    dma_pkg::avg_t                      window_average;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [dma_pkg::APB_ADDR_W-1:0]     paddr;
    logic [dma_pkg::APB_DATA_W-1:0]     pwdata;
    logic [dma_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    // boxcar model state
    int               window_cells [WINDOW_LEN];
    int               window_total;
    int               oldest_slot;
    dma_pkg::sample_t offset_setting;
    dma_pkg::avg_t    pending_averages [$];

    int      mismatch_count;
    int      quiet_cycles;
    int      sink_stall_pct;
    int      sink_hold_cycles;

    decimated_moving_average
    #(
        .WINDOW_LEN (WINDOW_LEN),
        .DECIMATION (DECIMATION)
    )
    i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .raw_sample     (raw_sample),
        .average_valid  (average_valid),
        .average_stall  (average_stall),
        .window_average (window_average),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic model_sample(input dma_pkg::sample_t raw);
        int level;
        begin
            level = int'(raw) - int'(offset_setting);
            window_total -= window_cells[oldest_slot];
            window_cells[oldest_slot] = level;
            window_total += level;
            oldest_slot = (oldest_slot + 1) % WINDOW_LEN;
            if ((oldest_slot % DECIMATION) == (1 % DECIMATION))
                pending_averages.push_back(dma_pkg::avg_t'(window_total / WINDOW_LEN));
        end
    endtask

    // valid is left high after the beat so back-to-back beats need no toggle
    task automatic send_sample(input dma_pkg::sample_t raw);
        begin
            sample_valid <= 1'b1;
            raw_sample   <= raw;
            @(posedge clk);
            while (sample_stall)
                @(posedge clk);
            model_sample(raw);
        end
    endtask

    task automatic drain_averages;
        begin
            sample_valid <= 1'b0;
            while (pending_averages.size() != 0)
                @(posedge clk);
            // a beat with no result may still be in the pipe
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [dma_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [dma_pkg::APB_DATA_W-1:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr;
            pwdata  <= data;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            if (dma_pkg::reg_index_t'(addr[2]) == dma_pkg::REG_SAMPLE_OFFSET)
                offset_setting = data[dma_pkg::SAMPLE_W-1:0];
        end
    endtask

    // runs of uniform values, held values (extremes among them) and values near the offset
    task automatic send_block(input int count, input int gap_pct);
        int               sent;
        int               burst;
        int               run_left;
        int               source;
        dma_pkg::sample_t held;
        dma_pkg::sample_t raw;
        begin
            sent     = 0;
            run_left = 0;
            source   = 0;
            held     = '0;
            while (sent < count)
            begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && sent < count)
                begin
                    if (run_left == 0)
                    begin
                        source   = $urandom_range(0, 3);
                        run_left = $urandom_range(1, 40);
                        if ($urandom_range(0, 1))
                            held = $urandom_range(0, 1) ? '1 : '0;
                        else
                            held = dma_pkg::sample_t'($urandom);
                    end
                    case (source)
                        0:       raw = dma_pkg::sample_t'($urandom);
                        1:       raw = held;
                        2:       raw = offset_setting
                                       + dma_pkg::sample_t'($urandom_range(0, 64)) - 16'd32;
                        default: raw = $urandom_range(0, 1) ? held
                                                            : dma_pkg::sample_t'($urandom);
                    endcase
                    send_sample(raw);
                    run_left--;
                    burst--;
                    sent++;
                end
                if ($urandom_range(0, 99) < gap_pct)
                begin
                    sample_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
        end
    endtask

    task automatic test_early_samples;
        begin
            // the window still holds reset zeros here
            sink_stall_pct = 0;
            send_sample(16'h0000);
            send_sample(16'hFFFF);
            send_sample(16'h5555);
            send_sample(16'hAAAA);
            send_sample(16'h0001);
            send_sample(16'h8000);
            drain_averages();
        end
    endtask

    task automatic test_offset_extremes;
        begin
            write_register(OFFSET_ADDR, 32'hFFFF_FFFF);
            send_sample(16'h0000);
            send_sample(16'h0000);
            send_sample(16'hFFFF);
            send_sample(16'h0000);
            send_sample(16'h0000);
            send_sample(16'h7FFF);
            drain_averages();
        end
    endtask

    task automatic test_unknown_register;
        begin
            write_register(OFFSET_ADDR, 32'h0000_1234);
            // index 1 does not exist, the offset must stay as it is
            write_register(UNKNOWN_ADDR, 32'hFFFF_0000);
            send_sample(16'h1234);
            send_sample(16'h0000);
            send_sample(16'hFFFF);
            send_sample(16'h1235);
            send_sample(16'h1233);
            drain_averages();
        end
    endtask

    task automatic test_random_setting(input dma_pkg::sample_t offset, input int count,
                                       input int gap_pct, input int stall_pct);
        begin
            write_register(OFFSET_ADDR, {16'($urandom_range(0, 65535)), offset});
            sink_stall_pct = stall_pct;
            send_block(count, gap_pct);
            drain_averages();
        end
    endtask

    task automatic test_output_hold;
        begin
            write_register(OFFSET_ADDR, 32'(16'h8000));
            sink_stall_pct   = 30;
            sink_hold_cycles = 300;
            // sender keeps offering while the output is held, so the input stalls
            send_block(200, 0);
            drain_averages();
        end
    endtask

    // receiver stall pattern, with an optional long hold
    initial
    begin : result_sink
        int  run_left;
        logic stall_now;
        run_left         = 0;
        stall_now        = 1'b0;
        sink_hold_cycles = 0;
        sink_stall_pct   = 0;
        average_stall   <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                average_stall <= 1'b1;
                sink_hold_cycles--;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stall_now = ($urandom_range(0, 99) < sink_stall_pct);
                    run_left  = $urandom_range(1, 6);
                end
                average_stall <= stall_now;
                run_left--;
            end
        end
    end

    always @(posedge clk)
    begin : average_check
        dma_pkg::avg_t expected;
        logic accepted;
        accepted = 1'b0;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                accepted = 1'b1;
            if (average_valid && !average_stall)
            begin
                accepted = 1'b1;
                if (pending_averages.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected average beat: window_average %0d",
                                 window_average);
                end
                else
                begin
                    expected = pending_averages.pop_front();
                    if (window_average !== expected)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("window_average mismatch: expected %0d, got %0d",
                                     expected, window_average);
                    end
                end
            end
        end
        quiet_cycles = accepted ? 0 : quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : test_sequence
        mismatch_count = 0;
        quiet_cycles   = 0;
        window_total   = 0;
        oldest_slot    = 0;
        offset_setting = '0;
        foreach (window_cells[i])
            window_cells[i] = 0;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        raw_sample   <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_early_samples();
        test_offset_extremes();
        test_unknown_register();
        test_random_setting(16'h0000, 260, 0, 0);
        test_random_setting(16'hFFFF, 260, 30, 25);
        test_random_setting(16'h8000, 260, 50, 50);
        test_random_setting(dma_pkg::sample_t'($urandom_range(1, 65534)), 260, 20, 10);
        test_output_hold();
        test_random_setting(dma_pkg::sample_t'($urandom_range(1, 65534)), 260, 40, 70);

        drain_averages();
        if (pending_averages.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected averages never arrived", pending_averages.size());
        end
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
